// ===== design/mbasc_pkg.sv =====
// Shared types, codes and the hex digit decoder for the Modbus ASCII receiver.
`timescale 1ns / 1ps

package mbasc_pkg;

  // input item commands
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SYMBOL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // frame end status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_BADCHAR = 3'd2;
  localparam logic [2:0] ST_ODD     = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;
  localparam logic [2:0] ST_LONG    = 3'd5;
  localparam logic [2:0] ST_ID      = 3'd6;
  localparam logic [2:0] ST_LRC     = 3'd7;

  // configuration register indexes
  localparam logic CFG_EXPECTED_ID   = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0]  EXPECTED_ID_RESET   = 8'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd5000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       is_last;
  } out_item_t;

  // bit 4 set means the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// ===== design/mbasc_frame.sv =====
// Frame state and per-item decode: hunt for ':', pair hex digits, LRC, end checks.
`timescale 1ns / 1ps

module mbasc_frame #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  mbasc_pkg::in_item_t  item,
  input  logic [7:0]           expected_id,
  input  logic [15:0]          timeout_ticks,
  output logic                 res_valid,
  output mbasc_pkg::out_item_t res
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] SAT_CNT = CW'(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MIN_CNT = CW'(4);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [15:0]   elapsed, elapsed_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic          nibble_pending, nibble_pending_next;
  logic          cr_seen, cr_seen_next;
  logic [7:0]    held_byte, held_byte_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    running_sum, running_sum_next;
  logic          id_mismatch, id_mismatch_next;

  logic [15:0] elapsed_inc;
  logic [4:0]  hv;
  logic [7:0]  new_byte;
  logic [2:0]  end_status;

  always_comb begin
    elapsed_inc = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    hv          = mbasc_pkg::hex_value(item.symbol);
    new_byte    = {high_nibble, hv[3:0]};
    if (nibble_pending) begin
      end_status = mbasc_pkg::ST_ODD;
    end else if (byte_count < MIN_CNT) begin
      end_status = mbasc_pkg::ST_SHORT;
    end else if (byte_count > MAX_CNT) begin
      end_status = mbasc_pkg::ST_LONG;
    end else if (id_mismatch) begin
      end_status = mbasc_pkg::ST_ID;
    end else if (running_sum != 8'd0) begin
      end_status = mbasc_pkg::ST_LRC;
    end else begin
      end_status = mbasc_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next          = phase;
    elapsed_next        = elapsed;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    cr_seen_next        = cr_seen;
    held_byte_next      = held_byte;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    id_mismatch_next    = id_mismatch;
    res_valid           = 1'b0;
    res                 = '0;

    if (fire) begin
      case (item.cmd)
        mbasc_pkg::CMD_START: begin
          phase_next          = PH_WAIT;
          elapsed_next        = '0;
          high_nibble_next    = '0;
          nibble_pending_next = 1'b0;
          cr_seen_next        = 1'b0;
          held_byte_next      = '0;
          byte_count_next     = '0;
          running_sum_next    = '0;
          id_mismatch_next    = 1'b0;
        end
        mbasc_pkg::CMD_TICK: begin
          if (phase != PH_IDLE) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= timeout_ticks) begin
              res_valid  = 1'b1;
              res.kind   = mbasc_pkg::KIND_END;
              res.status = mbasc_pkg::ST_TIMEOUT;
              res.is_last = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        mbasc_pkg::CMD_SYMBOL: begin
          if (phase == PH_WAIT) begin
            if (item.symbol == mbasc_pkg::CH_COLON) begin
              phase_next = PH_RECV;
            end
          end else if (phase == PH_RECV) begin
            if (cr_seen) begin
              res_valid   = 1'b1;
              res.kind    = mbasc_pkg::KIND_END;
              res.is_last = 1'b1;
              res.status  = (item.symbol == mbasc_pkg::CH_LF) ? end_status
                                                              : mbasc_pkg::ST_BADCHAR;
              phase_next  = PH_IDLE;
            end else if (item.symbol == mbasc_pkg::CH_CR) begin
              cr_seen_next = 1'b1;
            end else if (hv[4]) begin
              res_valid   = 1'b1;
              res.kind    = mbasc_pkg::KIND_END;
              res.is_last = 1'b1;
              res.status  = mbasc_pkg::ST_BADCHAR;
              phase_next  = PH_IDLE;
            end else if (!nibble_pending) begin
              high_nibble_next    = hv[3:0];
              nibble_pending_next = 1'b1;
            end else begin
              nibble_pending_next = 1'b0;
              if (byte_count >= MAX_CNT) begin
                // overlong: count saturates, nothing summed or sent
                byte_count_next = SAT_CNT;
              end else begin
                running_sum_next = running_sum + new_byte;
                byte_count_next  = byte_count + CW'(1);
                if (byte_count == '0) begin
                  id_mismatch_next = (new_byte != expected_id);
                end else begin
                  held_byte_next = new_byte;
                  // one byte behind so the LRC never goes out
                  if (byte_count >= CW'(2)) begin
                    res_valid     = 1'b1;
                    res.kind      = mbasc_pkg::KIND_DATA;
                    res.data_byte = held_byte;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      elapsed        <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      cr_seen        <= 1'b0;
      held_byte      <= '0;
      byte_count     <= '0;
      running_sum    <= '0;
      id_mismatch    <= 1'b0;
    end else begin
      phase          <= phase_next;
      elapsed        <= elapsed_next;
      high_nibble    <= high_nibble_next;
      nibble_pending <= nibble_pending_next;
      cr_seen        <= cr_seen_next;
      held_byte      <= held_byte_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      id_mismatch    <= id_mismatch_next;
    end
  end

endmodule

// ===== design/modbus_ascii_frame_receiver.sv =====
// Top level of the Modbus ASCII response receiver with LRC check.
//
// Input channel (in_valid/in_ready/in_data): one command per transfer:
// start, received character, or one timer tick. Output channel
// (out_valid/out_ready/out_data): decoded payload bytes, then one frame
// end result carrying the status. The slave id and the LRC byte are
// checked but never sent; payload bytes leave one byte behind the wire.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 expected id, 1 timeout in ticks), to be done while the block is idle.
// Throughput is one command per cycle while the output is not stalled. An
// accepted command is held in the input register while the frame logic
// decodes it; its result, if any, is loaded into the output register,
// which drives out_valid.
// If the output stalls with a result held, the command in the input
// register waits and in_ready drops until the held result is taken; an
// empty input register still takes one command first.
// Reset (rst, synchronous) empties both registers, puts the receiver idle
// (symbols and ticks ignored until a start) and loads expected id 1 and a
// timeout of 5000 ticks.
`timescale 1ns / 1ps

module modbus_ascii_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbasc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbasc_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [7:0]  expected_id;
  logic [15:0] timeout_ticks;

  logic                 s_valid;
  mbasc_pkg::in_item_t  s_item;
  logic                 adv;
  logic                 res_valid;
  mbasc_pkg::out_item_t res;

  assign adv      = s_valid && !(out_valid && !out_ready);
  assign in_ready = !s_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id   <= mbasc_pkg::EXPECTED_ID_RESET;
      timeout_ticks <= mbasc_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mbasc_pkg::CFG_EXPECTED_ID:   expected_id   <= cfg_data[7:0];
        mbasc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item <= in_data;
    end
  end

  mbasc_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .fire         (adv),
    .item         (s_item),
    .expected_id  (expected_id),
    .timeout_ticks(timeout_ticks),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// ===== dv/modbus_ascii_frame_receiver_test.sv =====
// Self-checking testbench: random Modbus ASCII frames against a cycle-free decoder model.
`timescale 1ns / 1ps

module modbus_ascii_frame_receiver_test;

  localparam int FRAME_MAX = 256;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {RX_IDLE, RX_HUNT, RX_FRAME} rx_phase_e;
  typedef enum int {
    FR_GOOD, FR_BAD_LRC, FR_BAD_ID, FR_ODD, FR_BADCHAR, FR_CR_NOT_LF,
    FR_LF_ALONE, FR_RESTART, FR_TIMEOUT, FR_TRUNC
  } frame_flaw_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mbasc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mbasc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  modbus_ascii_frame_receiver #(.MAX_FRAME_BYTES(FRAME_MAX)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // decoder state and register copies
  logic [7:0] cfg_id = mbasc_pkg::EXPECTED_ID_RESET;
  logic [15:0] cfg_timeout = mbasc_pkg::TIMEOUT_TICKS_RESET;
  rx_phase_e rx_phase = RX_IDLE;
  logic [15:0] rx_elapsed = '0;
  logic [3:0] rx_hi = '0;
  logic rx_hi_valid = 1'b0;
  logic rx_cr = 1'b0;
  logic [7:0] rx_held = '0;
  logic [10:0] rx_count = '0;
  logic [7:0] rx_sum = '0;
  logic rx_bad_id = 1'b0;

  mbasc_pkg::in_item_t cmd_q[$];
  mbasc_pkg::out_item_t decoded_q[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned tick_pct = 0;
  logic quiet = 1'b0;

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // 0..15 for a hex digit, 16 for anything else
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h10;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    return d[4:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + {4'h0, n};
    return ($urandom_range(0, 1) ? "a" : "A") + {4'h0, n} - 8'd10;
  endfunction

  function automatic void clear_frame();
    rx_elapsed = '0;
    rx_hi = '0;
    rx_hi_valid = 1'b0;
    rx_cr = 1'b0;
    rx_held = '0;
    rx_count = '0;
    rx_sum = '0;
    rx_bad_id = 1'b0;
  endfunction

  // advance the decoder by one command; returns 1 when it yields a result
  function automatic bit decode_step(input mbasc_pkg::in_item_t it,
                                     output mbasc_pkg::out_item_t r);
    logic [4:0] v;
    logic [7:0] b;
    bit emit;
    r = '0;
    r.kind = mbasc_pkg::KIND_END;
    r.is_last = 1'b1;
    if (it.cmd == mbasc_pkg::CMD_START) begin
      clear_frame();
      rx_phase = RX_HUNT;
      return 0;
    end
    if (it.cmd == mbasc_pkg::CMD_TICK) begin
      if (rx_phase == RX_IDLE) return 0;
      if (rx_elapsed != 16'hFFFF) rx_elapsed++;
      if (rx_elapsed < cfg_timeout) return 0;
      r.status = mbasc_pkg::ST_TIMEOUT;
      rx_phase = RX_IDLE;
      return 1;
    end
    if (it.cmd != mbasc_pkg::CMD_SYMBOL || rx_phase == RX_IDLE) return 0;
    if (rx_phase == RX_HUNT) begin
      if (it.symbol == mbasc_pkg::CH_COLON) rx_phase = RX_FRAME;
      return 0;
    end
    if (rx_cr) begin
      rx_phase = RX_IDLE;
      if (it.symbol != mbasc_pkg::CH_LF) r.status = mbasc_pkg::ST_BADCHAR;
      else if (rx_hi_valid) r.status = mbasc_pkg::ST_ODD;
      else if (rx_count < 11'd4) r.status = mbasc_pkg::ST_SHORT;
      else if (rx_count > FRAME_MAX) r.status = mbasc_pkg::ST_LONG;
      else if (rx_bad_id) r.status = mbasc_pkg::ST_ID;
      else if (rx_sum != 8'h00) r.status = mbasc_pkg::ST_LRC;
      else r.status = mbasc_pkg::ST_OK;
      return 1;
    end
    if (it.symbol == mbasc_pkg::CH_CR) begin
      rx_cr = 1'b1;
      return 0;
    end
    v = digit_of(it.symbol);
    if (v[4]) begin
      rx_phase = RX_IDLE;
      r.status = mbasc_pkg::ST_BADCHAR;
      return 1;
    end
    if (!rx_hi_valid) begin
      rx_hi = v[3:0];
      rx_hi_valid = 1'b1;
      return 0;
    end
    rx_hi_valid = 1'b0;
    b = {rx_hi, v[3:0]};
    // past the limit bytes are only counted, saturating
    if (rx_count >= FRAME_MAX) begin
      rx_count = FRAME_MAX[10:0] + 11'd1;
      return 0;
    end
    emit = 0;
    rx_sum = rx_sum + b;
    if (rx_count == 11'd0) begin
      rx_bad_id = (b != cfg_id);
    end else begin
      if (rx_count >= 11'd2) begin
        r = '0;
        r.kind = mbasc_pkg::KIND_DATA;
        r.data_byte = rx_held;
        emit = 1;
      end
      rx_held = b;
    end
    rx_count++;
    return emit;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  function automatic void push(input logic [1:0] c, input logic [7:0] s);
    mbasc_pkg::in_item_t it;
    it = {c, s};
    cmd_q.insert(cmd_q.size(), it);
    queued_total++;
  endfunction

  // symbol, sometimes preceded by a tick
  function automatic void push_sym(input logic [7:0] s);
    if (tick_pct != 0 && $urandom_range(1, 100) <= tick_pct)
      push(mbasc_pkg::CMD_TICK, rand_byte());
    push(mbasc_pkg::CMD_SYMBOL, s);
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    push_sym(digit_char(b[7:4]));
    push_sym(digit_char(b[3:0]));
  endfunction

  task automatic queue_frame(input int unsigned n_pay, input frame_flaw_e flaw);
    logic [7:0] sum, b;
    int unsigned n_bytes, cut;
    n_bytes = (flaw == FR_TRUNC) ? $urandom_range(0, 1) : n_pay + 2;
    cut = $urandom_range(0, n_bytes);
    sum = 8'h00;
    push(mbasc_pkg::CMD_START, rand_byte());
    repeat ($urandom_range(0, 2)) begin
      b = rand_byte();
      push_sym(b == mbasc_pkg::CH_COLON ? mbasc_pkg::CH_CR : b);
    end
    push_sym(mbasc_pkg::CH_COLON);
    for (int unsigned i = 0; i <= n_bytes; i++) begin
      if (i == cut) begin
        case (flaw)
          FR_BADCHAR: begin
            do b = rand_byte();
            while (digit_of(b) != 5'h10 || b == mbasc_pkg::CH_CR || b == mbasc_pkg::CH_LF);
            push_sym(b);
          end
          FR_RESTART: push(mbasc_pkg::CMD_START, rand_byte());
          FR_TIMEOUT: begin
            if (cfg_timeout <= 16'd64)
              repeat (cfg_timeout + 1) push(mbasc_pkg::CMD_TICK, rand_byte());
          end
          FR_ODD: push_sym(digit_char($urandom_range(0, 15)));
          default: ;
        endcase
      end
      if (i == n_bytes) break;
      if (i == 0) begin
        b = (flaw == FR_BAD_ID) ? cfg_id ^ (rand_byte() | 8'h01) : cfg_id;
      end else if (i == n_bytes - 1) begin
        b = 8'h00 - sum;
        if (flaw == FR_BAD_LRC) b = b ^ (rand_byte() | 8'h01);
      end else begin
        b = rand_byte();
      end
      sum = sum + b;
      push_hex_byte(b);
    end
    case (flaw)
      FR_CR_NOT_LF: begin
        push_sym(mbasc_pkg::CH_CR);
        do b = rand_byte(); while (b == mbasc_pkg::CH_LF);
        push_sym(b);
      end
      FR_LF_ALONE: push_sym(mbasc_pkg::CH_LF);
      default: begin
        push_sym(mbasc_pkg::CH_CR);
        push_sym(mbasc_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic queue_random(input int unsigned n_items);
    int unsigned goal, pick;
    logic [7:0] b;
    goal = queued_total + n_items;
    while (queued_total < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) begin
          b = rand_byte();
          push(b[1:0], rand_byte());
        end
      end else if (pick < 55) begin
        queue_frame($urandom_range(0, 8), FR_GOOD);
      end else begin
        queue_frame($urandom_range(0, 8), frame_flaw_e'($urandom_range(FR_BAD_LRC, FR_TRUNC)));
      end
    end
  endtask

  // sender holds off until every transfer is in and every result is out
  task automatic wait_idle();
    do @(posedge clk); while (accepted_total != queued_total || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mbasc_pkg::CFG_EXPECTED_ID) cfg_id = value[7:0];
    else cfg_timeout = value;
  endtask

  always @(posedge clk) begin : drive_in
    mbasc_pkg::out_item_t res;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      rx_phase = RX_IDLE;
      clear_frame();
    end else begin
      if (in_valid && in_ready) begin
        if (decode_step(in_data, res)) decoded_q.insert(decoded_q.size(), res);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= cmd_q.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    mbasc_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("result %h with nothing pending", out_data));
      end else begin
        want = decoded_q.pop_front();
        if (out_data.kind !== want.kind)
          flag_error($sformatf("kind got %b want %b", out_data.kind, want.kind));
        if (out_data.data_byte !== want.data_byte)
          flag_error($sformatf("data_byte got %h want %h", out_data.data_byte, want.data_byte));
        if (out_data.status !== want.status)
          flag_error($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.is_last !== want.is_last)
          flag_error($sformatf("is_last got %b want %b", out_data.is_last, want.is_last));
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle receiver ignores ticks, symbols and the unused command
    push(mbasc_pkg::CMD_TICK, 8'hFF);
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_COLON);
    push(CMD_NONE, 8'h00);
    // good frame, lower- and uppercase digits, junk before the colon
    push(mbasc_pkg::CMD_START, 8'h00);
    push(mbasc_pkg::CMD_SYMBOL, "x");
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_COLON);
    push(mbasc_pkg::CMD_SYMBOL, "0");
    push(mbasc_pkg::CMD_SYMBOL, "1");
    push(mbasc_pkg::CMD_SYMBOL, "a");
    push(mbasc_pkg::CMD_SYMBOL, "b");
    push(mbasc_pkg::CMD_SYMBOL, "F");
    push(mbasc_pkg::CMD_SYMBOL, "F");
    push(mbasc_pkg::CMD_SYMBOL, "5");
    push(mbasc_pkg::CMD_SYMBOL, "5");
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_CR);
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_LF);
    // restart drops the frame silently, then a bad character
    push(mbasc_pkg::CMD_START, 8'h00);
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_COLON);
    push(mbasc_pkg::CMD_SYMBOL, "0");
    push(mbasc_pkg::CMD_START, 8'hFF);
    push(mbasc_pkg::CMD_SYMBOL, mbasc_pkg::CH_COLON);
    push(mbasc_pkg::CMD_SYMBOL, "g");
    wait_idle();

    // reset settings, with a frame one byte past the length limit
    tick_pct = 0;
    queue_frame(FRAME_MAX - 1, FR_GOOD);
    tick_pct = 20;
    queue_random(90);
    wait_idle();

    write_reg(mbasc_pkg::CFG_EXPECTED_ID, {rand_byte(), 8'h00});
    write_reg(mbasc_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    tick_pct = 3;
    queue_random(90);
    wait_idle();

    write_reg(mbasc_pkg::CFG_EXPECTED_ID, {rand_byte(), 8'hFF});
    write_reg(mbasc_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
    tick_pct = 20;
    queue_random(100);
    wait_idle();

    write_reg(mbasc_pkg::CFG_EXPECTED_ID, {rand_byte(), rand_byte()});
    write_reg(mbasc_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    tick_pct = 2;
    queue_random(60);
    wait_idle();

    write_reg(mbasc_pkg::CFG_EXPECTED_ID, {rand_byte(), rand_byte()});
    write_reg(mbasc_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(8, 40)));
    tick_pct = 12;
    queue_random(90);
    wait_idle();

    // back-to-back transfers on both sides to finish
    quiet = 1'b1;
    queue_random(60);
    wait_idle();

    if (error_count == 0) begin
      $display("modbus_ascii_frame_receiver_test: done, clean");
    end else begin
      $display("modbus_ascii_frame_receiver_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(64'd10_000_000);
    $display("modbus_ascii_frame_receiver_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbasc_pkg.sv
design/mbasc_frame.sv
design/modbus_ascii_frame_receiver.sv
dv/modbus_ascii_frame_receiver_test.sv
